[rtl/tfpm_pkg.sv]
// ----------------------------------------------------------------------------
// tfpm_pkg
// Shared types, constants and check functions for the thermal frame checker.
// ----------------------------------------------------------------------------
package tfpm_pkg;

    localparam int PIXEL_COUNT = 8;
    localparam int LAST_POS    = 2 * PIXEL_COUNT + 2;
    localparam int POS_W       = $clog2(LAST_POS + 1);

    localparam logic [7:0]         POLY          = 8'h07;
    localparam logic signed [15:0] FLOOR_TENTHS  = -16'sd2732;
    localparam logic [6:0]         RESET_ADDRESS = 7'd10;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic       transfer_error;
    } t_item;

    typedef struct packed {
        logic signed [15:0] hottest_pixel;
        logic               frame_valid;
        logic               check_failed;
        logic               bus_failed;
        logic [7:0]         computed_check;
    } t_result;

    // one byte through the crc-8 register, msb first
    function automatic logic [7:0] crc_byte(input logic [7:0] v);
        logic [7:0] c;
        c = v;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ POLY) : (c << 1);
        end
        return c;
    endfunction

    // crc of the 8-bit read address
    function automatic logic [7:0] seed_of(input logic [6:0] addr);
        return crc_byte({addr, 1'b1});
    endfunction

endpackage

[rtl/tfpm_frame.sv]
// ----------------------------------------------------------------------------
// tfpm_frame
// Frame position, crc accumulator and running maximum for one byte per cycle while i_fire is high.
// ----------------------------------------------------------------------------
module tfpm_frame
    import tfpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_item      i_item,
    input  logic [6:0] i_address,
    output logic       o_last,
    output t_result    o_res
);

    logic [POS_W-1:0]   r_pos, n_pos;
    logic [7:0]         r_acc, n_acc;
    logic [7:0]         r_held, n_held;
    logic signed [15:0] r_max, n_max;
    logic               r_fault, n_fault;

    logic [POS_W-1:0]   pos_eff;
    logic               first;
    logic [7:0]         acc_base;
    logic               fault_now;
    logic signed [15:0] max_base;
    logic signed [15:0] pix;
    logic [7:0]         crc_next;
    logic               bad_check;
    logic               ok;

    always_comb begin
        pos_eff   = (i_item.frame_start || r_pos > POS_W'(LAST_POS)) ? '0 : r_pos;
        first     = (pos_eff == '0);
        acc_base  = first ? seed_of(i_address) : r_acc;
        fault_now = (first ? 1'b0 : r_fault) | i_item.transfer_error;
        max_base  = first ? FLOOR_TENTHS : r_max;
        o_last    = (pos_eff == POS_W'(LAST_POS));
        crc_next  = crc_byte(acc_base ^ i_item.rx_byte);
        pix       = $signed({i_item.rx_byte, r_held});
        bad_check = (acc_base != i_item.rx_byte);
        ok        = !bad_check && !fault_now;

        o_res.hottest_pixel  = ok ? max_base : FLOOR_TENTHS;
        o_res.frame_valid    = ok;
        o_res.check_failed   = bad_check;
        o_res.bus_failed     = fault_now;
        o_res.computed_check = acc_base;
    end

    always_comb begin
        n_pos   = r_pos;
        n_acc   = r_acc;
        n_held  = r_held;
        n_max   = r_max;
        n_fault = r_fault;
        if (i_fire) begin
            n_fault = fault_now;
            n_acc   = acc_base;
            n_max   = max_base;
            if (o_last) begin
                n_pos = '0;
            end else begin
                n_acc = crc_next;
                n_pos = pos_eff + POS_W'(1);
                if (pos_eff >= POS_W'(2)) begin
                    if (!pos_eff[0]) begin
                        n_held = i_item.rx_byte;
                    end else if (pix > max_base) begin
                        n_max = pix;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_acc   <= seed_of(RESET_ADDRESS);
            r_held  <= '0;
            r_max   <= FLOOR_TENTHS;
            r_fault <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_held  <= n_held;
            r_max   <= n_max;
            r_fault <= n_fault;
        end
    end

    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_last |=> r_pos == '0)
        else $error("position not cleared after check byte");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(LAST_POS))
        else $error("position beyond frame length");

    a_valid_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |-> o_res.frame_valid == !(o_res.check_failed || o_res.bus_failed))
        else $error("frame_valid disagrees with failure flags");

    a_reject_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !o_res.frame_valid |-> o_res.hottest_pixel == FLOOR_TENTHS)
        else $error("rejected frame does not report floor");

endmodule

[rtl/tfpm_out.sv]
// ----------------------------------------------------------------------------
// tfpm_out
// Result register holding one item until the receiver takes it.
// ----------------------------------------------------------------------------
module tfpm_out
    import tfpm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid, n_valid;
    t_result r_res, n_res;

    always_comb begin
        o_free  = !r_valid || i_ready;
        n_valid = i_load ? 1'b1 : (i_ready ? 1'b0 : r_valid);
        n_res   = i_load ? i_res : r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[rtl/thermal_frame_pec_max_core.sv]
// ----------------------------------------------------------------------------
// thermal_frame_pec_max_core
// Thermopile read frame checker: crc-8 packet error check and hottest pixel.
//
// Input channel: one received byte per item with frame_start and
// transfer_error flags (i_in_valid / o_in_ready). A frame is a 2-byte
// reference word, PIXEL_COUNT little-endian pixels, then the check byte.
// Output channel: one item per frame, produced on the check byte
// (o_out_valid / i_out_ready). Other bytes give no output.
// Configuration: i_cfg_wr_en writes the seven-bit device address, which
// seeds the check at the next frame start; write only while idle.
// Path: an item goes through an input register and the frame logic into
// the result register. Throughput is one byte per cycle, set by the
// combinational crc byte update and pixel compare, while no check byte
// waits for a full result register.
// Reset clears position, flags and the result valid bit; the address
// returns to 10. While the receiver stalls, bytes that give no output keep
// flowing; a check byte waits in the input register until the result
// register frees, and input is held off while it waits.
// ----------------------------------------------------------------------------
module thermal_frame_pec_max_core
    import tfpm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [6:0]         i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_start,
    input  logic               i_transfer_error,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_hottest_pixel,
    output logic               o_frame_valid,
    output logic               o_check_failed,
    output logic               o_bus_failed,
    output logic [7:0]         o_computed_check
);

    logic [6:0] r_address;
    logic       r_s1_valid, n_s1_valid;
    t_item      r_s1, n_s1;

    logic       s1_fire;
    logic       in_fire;
    logic       last;
    logic       out_free;
    t_result    res;
    t_result    out_res;

    // byte stage advances unless a check byte meets a full result register that the receiver does not take
    always_comb begin
        s1_fire    = r_s1_valid && (!last || out_free);
        o_in_ready = !r_s1_valid || s1_fire;
        in_fire    = i_in_valid && o_in_ready;
        n_s1_valid = in_fire ? 1'b1 : (s1_fire ? 1'b0 : r_s1_valid);
        n_s1       = in_fire ? t_item'{i_rx_byte, i_frame_start, i_transfer_error} : r_s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address  <= RESET_ADDRESS;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_address <= i_cfg_wr_data;
            end
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    tfpm_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (s1_fire),
        .i_item    (r_s1),
        .i_address (r_address),
        .o_last    (last),
        .o_res     (res)
    );

    tfpm_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_fire && last),
        .i_res   (res),
        .i_ready (i_out_ready),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_hottest_pixel  = out_res.hottest_pixel;
    assign o_frame_valid    = out_res.frame_valid;
    assign o_check_failed   = out_res.check_failed;
    assign o_bus_failed     = out_res.bus_failed;
    assign o_computed_check = out_res.computed_check;

endmodule

[bench/tb_thermal_frame_pec_max_core.sv]
// ----------------------------------------------------------------------------
// tb_thermal_frame_pec_max_core
// Self-checking bench for the thermopile frame checker. Bytes go in one item
// at a time with random gaps while the result side stalls at random. A
// bit-level model of the crc-8 and of the pixel maximum predicts every frame
// verdict, and each result item is compared field by field. A short table
// comes first: an early restart, a frame at the floor, and a back-to-back
// frame with extreme pixels. Random phases follow, each after setting a
// device address, mixing clean frames, broken frames and noise.
// ----------------------------------------------------------------------------
module tb_thermal_frame_pec_max_core;
    import tfpm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 240;

    typedef enum logic [1:0] {CHK_AS_GIVEN, CHK_GOOD} t_chk_mode;

    typedef struct {
        logic [7:0]         data;
        bit                 start;
        bit                 err;
        t_chk_mode          chk;
        bit                 pinned;
        logic signed [15:0] hot;
        bit                 ok;
        bit                 crc_bad;
        bit                 bus_bad;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [6:0]         i_cfg_wr_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [7:0]         i_rx_byte;
    logic               i_frame_start;
    logic               i_transfer_error;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [15:0] o_hottest_pixel;
    logic               o_frame_valid;
    logic               o_check_failed;
    logic               o_bus_failed;
    logic [7:0]         o_computed_check;

    // frame model state
    int                 pos_q;
    logic [7:0]         pec_acc;
    logic [7:0]         low_byte;
    logic signed [15:0] hot_max;
    bit                 fault;
    logic [6:0]         dev_addr;

    t_result   verdicts_due[$];
    t_stim_row plan[$];
    t_result   want;
    int        err_count;
    int        items_sent;
    int        idle_pct;
    int        stall_pct;
    int        quiet_cycles;

    thermal_frame_pec_max_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .i_frame_start    (i_frame_start),
        .i_transfer_error (i_transfer_error),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_hottest_pixel  (o_hottest_pixel),
        .o_frame_valid    (o_frame_valid),
        .o_check_failed   (o_check_failed),
        .o_bus_failed     (o_bus_failed),
        .o_computed_check (o_computed_check)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic [7:0] pec_update(input logic [7:0] v);
        logic [7:0] c;
        c = v;
        repeat (8) begin
            if (c[7]) c = {c[6:0], 1'b0} ^ POLY;
            else c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic bit advance_frame(input logic [7:0] b, input bit st, input bit er,
                                         output t_result r);
        logic [15:0] raw;
        r = '0;
        if (st || pos_q > LAST_POS) pos_q = 0;
        if (pos_q == 0) begin
            pec_acc = pec_update({dev_addr, 1'b1});
            fault   = 1'b0;
            hot_max = FLOOR_TENTHS;
        end
        if (er) fault = 1'b1;
        if (pos_q < LAST_POS) begin
            pec_acc = pec_update(pec_acc ^ b);
            if (pos_q >= 2) begin
                if (pos_q % 2 == 0) begin
                    low_byte = b;
                end else begin
                    raw = {b, low_byte};
                    if ($signed(raw) > hot_max) hot_max = raw;
                end
            end
            pos_q++;
            return 1'b0;
        end
        r.check_failed   = (pec_acc != b);
        r.bus_failed     = fault;
        r.frame_valid    = !r.check_failed && !fault;
        r.hottest_pixel  = r.frame_valid ? hot_max : FLOOR_TENTHS;
        r.computed_check = pec_acc;
        pos_q = 0;
        return 1'b1;
    endfunction

    function automatic logic signed [15:0] pick_pixel();
        case ($urandom_range(5))
            0: pick_pixel = 16'($urandom);
            1: pick_pixel = 16'(int'(FLOOR_TENTHS) + int'($urandom_range(4)) - 2);
            2: pick_pixel = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: pick_pixel = 16'(int'($urandom_range(550)) - 100);
        endcase
    endfunction

    task automatic report(input string what);
        $display("mismatch: %s", what);
        err_count++;
    endtask

    task automatic add_row(input logic [7:0] d, input bit s, input bit e, input t_chk_mode c,
                           input bit p, input logic signed [15:0] h, input bit ok,
                           input bit cb, input bit bb);
        t_stim_row row;
        row.data    = d;
        row.start   = s;
        row.err     = e;
        row.chk     = c;
        row.pinned  = p;
        row.hot     = h;
        row.ok      = ok;
        row.crc_bad = cb;
        row.bus_bad = bb;
        plan.push_back(row);
    endtask

    task automatic send(input logic [7:0] b, input bit st, input bit er,
                        output bit got, output t_result r);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_rx_byte        <= b;
        i_frame_start    <= st;
        i_transfer_error <= er;
        do @(posedge i_clk); while (!o_in_ready);
        got = advance_frame(b, st, er, r);
        items_sent++;
    endtask

    task automatic drive_item(input logic [7:0] b, input bit st, input bit er);
        bit      got;
        t_result r;
        send(b, st, er, got, r);
        if (got) verdicts_due.push_back(r);
    endtask

    task automatic send_frame(input int target);
        int                 n;
        int                 n0;
        int                 stop;
        int                 err_at;
        int                 pick;
        logic [7:0]         b;
        logic signed [15:0] px;
        bit                 st;
        // sometimes carry on with a frame left open, otherwise begin afresh
        n0     = (pos_q != 0 && $urandom_range(1) == 1) ? pos_q : 0;
        stop   = ($urandom_range(9) == 0) ? $urandom_range(n0, LAST_POS) : LAST_POS;
        err_at = ($urandom_range(7) == 0) ? $urandom_range(n0, LAST_POS) : -1;
        px     = pick_pixel();
        for (n = n0; n <= stop && items_sent < target; n++) begin
            st = (n == 0) && (pos_q != 0 || $urandom_range(1) == 1);
            if (n < 2) begin
                b = 8'($urandom);
            end else if (n < LAST_POS) begin
                if (n % 2 == 0) px = pick_pixel();
                b = (n % 2 == 0) ? px[7:0] : px[15:8];
            end else begin
                pick = $urandom_range(19);
                if (pick < 14) b = pec_acc;
                else if (pick < 17) b = pec_acc ^ (8'h01 << $urandom_range(7));
                else b = 8'($urandom);
            end
            drive_item(b, st, n == err_at);
        end
    endtask

    task automatic set_address(input logic [6:0] a);
        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= a;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        dev_addr = a;
    endtask

    // result side
    initial begin
        forever begin
            if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdicts_due.size() == 0) begin
                report("result item with none due");
            end else begin
                want = verdicts_due.pop_front();
                if (o_hottest_pixel !== want.hottest_pixel)
                    report($sformatf("hottest_pixel %0d, want %0d",
                                     o_hottest_pixel, want.hottest_pixel));
                if (o_frame_valid !== want.frame_valid)
                    report($sformatf("frame_valid %b, want %b", o_frame_valid, want.frame_valid));
                if (o_check_failed !== want.check_failed)
                    report($sformatf("check_failed %b, want %b",
                                     o_check_failed, want.check_failed));
                if (o_bus_failed !== want.bus_failed)
                    report($sformatf("bus_failed %b, want %b", o_bus_failed, want.bus_failed));
                if (o_computed_check !== want.computed_check)
                    report($sformatf("computed_check %h, want %h",
                                     o_computed_check, want.computed_check));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int                 k;
        int                 p;
        int                 target;
        logic [7:0]         b;
        bit                 got;
        t_result            r;
        logic signed [15:0] floor_px [PIXEL_COUNT];
        logic signed [15:0] hot_px [PIXEL_COUNT];

        i_rst_n          <= 1'b0;
        i_cfg_wr_en      <= 1'b0;
        i_cfg_wr_data    <= '0;
        i_in_valid       <= 1'b0;
        i_rx_byte        <= '0;
        i_frame_start    <= 1'b0;
        i_transfer_error <= 1'b0;
        err_count    = 0;
        items_sent   = 0;
        quiet_cycles = 0;
        idle_pct     = 15;
        stall_pct    = 15;

        dev_addr = RESET_ADDRESS;
        pos_q    = 0;
        pec_acc  = pec_update({RESET_ADDRESS, 1'b1});
        low_byte = '0;
        hot_max  = FLOOR_TENTHS;
        fault    = 1'b0;

        floor_px = '{-16'sd2732, 16'sh8000, -16'sd2733, -16'sd2732,
                     -16'sd3000, -16'sd2732, -16'sd10000, -16'sd2800};
        hot_px   = '{16'sh8000, -16'sd2732, -16'sd2733, 16'sd0,
                     -16'sd1, 16'sh7FFF, 16'sh7FFE, 16'sd1};

        // early restart: dropped without a result by the next frame_start
        add_row(8'h5A, 1, 0, CHK_AS_GIVEN, 0, 0, 0, 0, 0);
        add_row(8'hA5, 0, 1, CHK_AS_GIVEN, 0, 0, 0, 0, 0);
        add_row(8'h3C, 0, 0, CHK_AS_GIVEN, 0, 0, 0, 0, 0);
        // pixels at or below the floor, bus error on the check byte
        add_row(8'h00, 1, 0, CHK_AS_GIVEN, 0, 0, 0, 0, 0);
        add_row(8'hFF, 0, 0, CHK_AS_GIVEN, 0, 0, 0, 0, 0);
        for (k = 0; k < PIXEL_COUNT; k++) begin
            add_row(floor_px[k][7:0], 0, 0, CHK_AS_GIVEN, 0, 0, 0, 0, 0);
            add_row(floor_px[k][15:8], 0, 0, CHK_AS_GIVEN, 0, 0, 0, 0, 0);
        end
        add_row(8'h00, 0, 1, CHK_GOOD, 1, FLOOR_TENTHS, 0, 0, 1);
        // back to back with no frame_start, extreme pixels, clean check
        add_row(8'hFF, 0, 0, CHK_AS_GIVEN, 0, 0, 0, 0, 0);
        add_row(8'h00, 0, 0, CHK_AS_GIVEN, 0, 0, 0, 0, 0);
        for (k = 0; k < PIXEL_COUNT; k++) begin
            add_row(hot_px[k][7:0], 0, 0, CHK_AS_GIVEN, 0, 0, 0, 0, 0);
            add_row(hot_px[k][15:8], 0, 0, CHK_AS_GIVEN, 0, 0, 0, 0, 0);
        end
        add_row(8'h00, 0, 0, CHK_GOOD, 1, 16'sh7FFF, 1, 0, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            b = (plan[i].chk == CHK_GOOD) ? pec_acc : plan[i].data;
            send(b, plan[i].start, plan[i].err, got, r);
            if (got) begin
                if (plan[i].pinned) begin
                    r.hottest_pixel = plan[i].hot;
                    r.frame_valid   = plan[i].ok;
                    r.check_failed  = plan[i].crc_bad;
                    r.bus_failed    = plan[i].bus_bad;
                end
                verdicts_due.push_back(r);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            if (p == 0) set_address(7'd0);
            else if (p == 1) set_address(7'd127);
            else set_address(7'($urandom_range(127)));
            case (p)
                0: idle_pct = 20;
                1: idle_pct = 0;
                2: idle_pct = 40;
                3: idle_pct = 10;
                4: idle_pct = 60;
                5: idle_pct = 25;
                default: idle_pct = 0;
            endcase
            stall_pct = idle_pct;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(15) == 0) begin
                    repeat ($urandom_range(1, 3))
                        drive_item(8'($urandom), $urandom_range(3) == 0,
                                   $urandom_range(7) == 0);
                end else begin
                    send_frame(target);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0 && verdicts_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
